>>> rtl/rmdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmdc_pkg
// Shared widths, defaults and control types for the row divisor-count selector.
// ----------------------------------------------------------------------------
package rmdc_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int MAX_ROWS_DEF   = 32;

  localparam int COUNT_W = 7;
  localparam int INDEX_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic start;
  } rem_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_sts_t;

endpackage
`default_nettype wire

>>> rtl/rmdc_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmdc channel interfaces
// Valid/ready channels for element requests and row results.
// ----------------------------------------------------------------------------
interface rmdc_in_if #(
  parameter int VALUE_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] element_value;
  logic                         row_end;
  logic                         matrix_end;

  modport source (output valid, output element_value, output row_end,
                  output matrix_end, input ready);
  modport sink   (input valid, input element_value, input row_end,
                  input matrix_end, output ready);
endinterface

interface rmdc_out_if #(
  parameter int VALUE_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic [4:0]                   row_index;
  logic signed [VALUE_BITS-1:0] best_value;
  logic [6:0]                   divisor_count;

  modport source (output valid, output row_index, output best_value,
                  output divisor_count, input ready);
  modport sink   (input valid, input row_index, input best_value,
                  input divisor_count, output ready);
endinterface
`default_nettype wire

>>> rtl/rmdc_rem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmdc_rem
// Restoring remainder unit, one dividend bit per cycle; flags a zero remainder.
// ----------------------------------------------------------------------------
module rmdc_rem
  import rmdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rem_ctl_t              ctl,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [VALUE_BITS-1:0] divisor,
  output rem_sts_t                   sts
);

  localparam int STEP_W = $clog2(VALUE_BITS + 1);

  logic                  busy_r;
  logic                  done_r;
  logic                  zero_r;
  logic [STEP_W-1:0]     step_r;
  logic [VALUE_BITS-1:0] dvd_r;
  logic [VALUE_BITS-1:0] dsr_r;
  logic [VALUE_BITS-1:0] rem_r;

  logic [VALUE_BITS:0]   shifted;
  logic [VALUE_BITS:0]   diff;
  logic                  ge;
  logic [VALUE_BITS-1:0] rem_nxt;

  assign shifted = {rem_r, dvd_r[VALUE_BITS-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};
  assign rem_nxt = ge ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(VALUE_BITS);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
      if (step_r == STEP_W'(1)) begin
        zero_r <= (rem_nxt == '0);
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.zero = zero_r;

`ifndef ASSERT_OFF
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !$past(ctl.start) |-> rem_r < dsr_r)
    else $error("remainder not below divisor");
`endif

endmodule
`default_nettype wire

>>> rtl/rmdc_cnt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmdc_cnt
// Divisor-count sequencer: steps trial divisors up to the square root and
// drives the shared remainder unit for each one.
// ----------------------------------------------------------------------------
module rmdc_cnt
  import rmdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] n,
  output logic                       done,
  output logic [COUNT_W-1:0]         count,
  output rem_ctl_t                   rem_ctl,
  output logic [VALUE_BITS-1:0]      rem_dividend,
  output logic [VALUE_BITS-1:0]      rem_divisor,
  input  wire rem_sts_t              rem_sts
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_TEST = 2'd1;
  localparam logic [1:0] C_WAIT = 2'd2;

  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  logic                  done_r;
  logic [VALUE_BITS-1:0] n_r;
  logic [VALUE_BITS-1:0] i_r;
  logic [VALUE_BITS:0]   sq_r;
  logic [COUNT_W-1:0]    cnt_r;

  logic                  in_range;
  logic                  is_root;
  logic [COUNT_W:0]      sum;
  logic [COUNT_W-1:0]    cnt_sat;

  assign in_range = sq_r <= {1'b0, n_r};
  assign is_root  = sq_r == {1'b0, n_r};
  assign sum      = {1'b0, cnt_r} + (is_root ? (COUNT_W+1)'(1) : (COUNT_W+1)'(2));
  assign cnt_sat  = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      C_IDLE: if (start) state_nxt = C_TEST;
      C_TEST: state_nxt = in_range ? C_WAIT : C_IDLE;
      C_WAIT: if (rem_sts.done) state_nxt = C_TEST;
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == C_TEST) && !in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && start) begin
      n_r   <= n;
      i_r   <= VALUE_BITS'(1);
      sq_r  <= (VALUE_BITS+1)'(1);
      cnt_r <= '0;
    end else if (state_r == C_WAIT && rem_sts.done) begin
      if (rem_sts.zero) begin
        cnt_r <= cnt_sat;
      end
      i_r  <= i_r + VALUE_BITS'(1);
      sq_r <= sq_r + {i_r, 1'b1};
    end
  end

  assign rem_ctl.start = (state_r == C_TEST) && in_range;
  assign rem_dividend  = n_r;
  assign rem_divisor   = i_r;
  assign done          = done_r;
  assign count         = cnt_r;

`ifndef ASSERT_OFF
  a_nonzero_has_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && (n_r != '0) |-> cnt_r != '0)
    else $error("nonzero value finished with no divisors");

  a_wait_has_unit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == C_WAIT |-> rem_sts.busy || rem_sts.done)
    else $error("waiting on an idle remainder unit");
`endif

endmodule
`default_nettype wire

>>> rtl/row_max_divisor_count_selector_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// row_max_divisor_count_selector_unit
// Per-row selection of the first element with the most positive divisors.
// ----------------------------------------------------------------------------
// Elements arrive in row order; each one is held until its divisor count is
// known, then ready rises again. Trial divisors up to the square root go one
// at a time through a single restoring remainder unit that retires one
// dividend bit per cycle, and each divisor found below the root adds two to
// the count. A row-end request produces one result; it waits in the output
// register, and a later row end stalls only while that result is still
// untaken. A matrix end on a row-end request returns the row index to zero,
// as does a row end on the last row.
// ----------------------------------------------------------------------------
module row_max_divisor_count_selector_unit
  import rmdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rmdc_in_if.sink    in_chan,
  rmdc_out_if.source out_chan
);

  localparam int ROW_W = $clog2(MAX_ROWS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_COUNT = 2'd1;
  localparam logic [1:0] S_UPD   = 2'd2;

  logic [1:0]            state_r;
  logic                  rend_r;
  logic                  mend_r;
  logic [VALUE_BITS-1:0] elem_r;
  logic [COUNT_W-1:0]    item_cnt_r;
  logic [COUNT_W-1:0]    best_cnt_r;
  logic [VALUE_BITS-1:0] best_elem_r;
  logic                  open_r;
  logic [ROW_W-1:0]      row_r;
  logic                  out_valid_r;
  logic [INDEX_W-1:0]    out_idx_r;
  logic [VALUE_BITS-1:0] out_val_r;
  logic [COUNT_W-1:0]    out_cnt_r;

  logic                  in_fire;
  logic [VALUE_BITS-1:0] elem_u;
  logic [VALUE_BITS-1:0] mag;
  logic                  take;
  logic [COUNT_W-1:0]    nb_cnt;
  logic [VALUE_BITS-1:0] nb_elem;
  logic                  emit;
  logic                  row_done;
  logic [ROW_W+INDEX_W-1:0] row_ext;

  logic                  cnt_done;
  logic [COUNT_W-1:0]    cnt_count;
  rem_ctl_t              rem_ctl;
  rem_sts_t              rem_sts;
  logic [VALUE_BITS-1:0] rem_dividend;
  logic [VALUE_BITS-1:0] rem_divisor;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign elem_u        = in_chan.element_value;
  assign mag           = elem_u[VALUE_BITS-1] ? (~elem_u + VALUE_BITS'(1)) : elem_u;

  assign take     = !open_r || (item_cnt_r > best_cnt_r);
  assign nb_cnt   = take ? item_cnt_r : best_cnt_r;
  assign nb_elem  = take ? elem_r : best_elem_r;
  assign emit     = (state_r == S_UPD) && rend_r && (!out_valid_r || out_chan.ready);
  assign row_done = (state_r == S_UPD) && (!rend_r || emit);
  assign row_ext  = {{INDEX_W{1'b0}}, row_r};

  rmdc_cnt #(
    .VALUE_BITS(VALUE_BITS)
  ) u_cnt (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (in_fire),
    .n            (mag),
    .done         (cnt_done),
    .count        (cnt_count),
    .rem_ctl      (rem_ctl),
    .rem_dividend (rem_dividend),
    .rem_divisor  (rem_divisor),
    .rem_sts      (rem_sts)
  );

  rmdc_rem #(
    .VALUE_BITS(VALUE_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (rem_ctl),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .sts      (rem_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      best_cnt_r  <= '0;
      best_elem_r <= '0;
      open_r      <= 1'b0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE:  if (in_fire) state_r <= S_COUNT;
        S_COUNT: if (cnt_done) state_r <= S_UPD;
        S_UPD:   if (row_done) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase

      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == S_UPD && !rend_r) begin
        best_cnt_r  <= nb_cnt;
        best_elem_r <= nb_elem;
        open_r      <= 1'b1;
      end else if (emit) begin
        best_cnt_r  <= '0;
        best_elem_r <= '0;
        open_r      <= 1'b0;
        if (mend_r || row_r == ROW_W'(MAX_ROWS - 1)) begin
          row_r <= '0;
        end else begin
          row_r <= row_r + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      elem_r <= elem_u;
      rend_r <= in_chan.row_end;
      mend_r <= in_chan.matrix_end;
    end
    if (state_r == S_COUNT && cnt_done) begin
      item_cnt_r <= cnt_count;
    end
    if (emit) begin
      out_idx_r <= row_ext[INDEX_W-1:0];
      out_val_r <= nb_elem;
      out_cnt_r <= nb_cnt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.row_index     = out_idx_r;
  assign out_chan.best_value    = out_val_r;
  assign out_chan.divisor_count = out_cnt_r;

`ifndef ASSERT_OFF
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_COUNT)
    else $error("request accepted without starting the count");

  a_result_from_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_UPD && rend_r))
    else $error("result raised without a row end");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_W'(MAX_ROWS - 1))
    else $error("row counter past last row");
`endif

endmodule
`default_nettype wire
